### hdl/nsk_pkg.sv
// Shared constants, types and helper functions of the n-gram spectrum kernel.
`timescale 1ns / 1ps
`default_nettype none

package nsk_pkg;

    // Default sizing of the design
    localparam int unsigned MAX_GRAM_DEF    = 8;
    localparam int unsigned MAX_SEQ_LEN_DEF = 65536;

    // Fixed field widths
    localparam int unsigned GRAM_W   = 4;
    localparam int unsigned SYM_W    = 2;
    localparam int unsigned BIN_W    = 17;
    localparam int unsigned PROD_W   = 2 * BIN_W;
    localparam int unsigned KERNEL_W = 33;
    localparam int unsigned WIN_W    = 17;

    localparam logic [GRAM_W-1:0]   GRAM_RESET = 4'd3;
    localparam logic [SYM_W-1:0]    SYM_MAX    = 2'd2;
    localparam logic [BIN_W-1:0]    BIN_MAX    = {BIN_W{1'b1}};
    localparam logic [KERNEL_W-1:0] KERNEL_MAX = {KERNEL_W{1'b1}};

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;     // capture an input transaction
        logic inc_wr;   // write back the incremented bins
        logic sweep;    // write zero at the sweep address and advance it
        logic sum;      // the sweep read feeds the dot product
        logic finish;   // publish the result and clear the pair state
    } nsk_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic sweep_end;  // sweep address sits on the last bin
        logic last;       // captured transaction closes the pair
    } nsk_sts_t;

    // Integer power of three, for elaboration-time sizing
    function automatic int unsigned pow3(input int unsigned e);
        int unsigned r;
        r = 1;
        for (int unsigned i = 0; i < e; i++) begin
            r = r * 3;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/nsk_ctrl.sv
// Controller state machine of the n-gram spectrum kernel.
`timescale 1ns / 1ps
`default_nettype none

module nsk_ctrl
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  wire logic             out_stall,
    input  wire nsk_pkg::nsk_sts_t sts,
    output nsk_pkg::nsk_cmd_t     cmd
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_RD,
        S_WR,
        S_WALK,
        S_FLUSH1,
        S_FLUSH2,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   ready;
    logic   in_take;

    // Take a transaction when idle, or while the previous one writes back and leaves the pair open
    always_comb
    begin
        ready   = (state_reg == S_IDLE) || ((state_reg == S_WR) && !sts.last);
        in_take = in_valid && ready;
    end

    // Decode commands
    always_comb
    begin
        cmd.load   = in_take;
        cmd.inc_wr = (state_reg == S_WR);
        cmd.sweep  = (state_reg == S_INIT) || (state_reg == S_WALK);
        cmd.sum    = (state_reg == S_WALK);
        cmd.finish = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    end

    // Next state and result valid
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                if (sts.sweep_end)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_take)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_WR;
            end
            S_WR:
            begin
                if (sts.last)
                begin
                    state_next = S_WALK;
                end
                else if (in_take)
                begin
                    state_next = S_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_WALK:
            begin
                if (sts.sweep_end)
                begin
                    state_next = S_FLUSH1;
                end
            end
            S_FLUSH1:
            begin
                state_next = S_FLUSH2;
            end
            S_FLUSH2:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (cmd.finish)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
        out_valid_next = cmd.finish || (out_valid_reg && out_stall);
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = !ready;
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

### hdl/nsk_datapath.sv
// Datapath of the n-gram spectrum kernel: windows, histograms and dot product.
`timescale 1ns / 1ps
`default_nettype none

module nsk_datapath
#(
    parameter int unsigned MAX_GRAM    = nsk_pkg::MAX_GRAM_DEF,
    parameter int unsigned MAX_SEQ_LEN = nsk_pkg::MAX_SEQ_LEN_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [nsk_pkg::GRAM_W-1:0]    cfg_data,
    input  wire logic [nsk_pkg::SYM_W-1:0]     symbol_a,
    input  wire logic [nsk_pkg::SYM_W-1:0]     symbol_b,
    input  wire logic                          last,
    input  wire nsk_pkg::nsk_cmd_t             cmd,
    output nsk_pkg::nsk_sts_t                  sts,
    output logic [nsk_pkg::KERNEL_W-1:0]       kernel_value,
    output logic [nsk_pkg::WIN_W-1:0]          windows_counted
);

    localparam int unsigned DEPTH    = nsk_pkg::pow3(MAX_GRAM);
    localparam int unsigned ADDR_W   = $clog2(DEPTH);
    localparam int unsigned SEEN_W   = $clog2(MAX_SEQ_LEN + 1);
    localparam int unsigned GRAM_W   = nsk_pkg::GRAM_W;
    localparam int unsigned SYM_W    = nsk_pkg::SYM_W;
    localparam int unsigned BIN_W    = nsk_pkg::BIN_W;
    localparam int unsigned PROD_W   = nsk_pkg::PROD_W;
    localparam int unsigned KERNEL_W = nsk_pkg::KERNEL_W;
    localparam int unsigned WIN_W    = nsk_pkg::WIN_W;

    logic [GRAM_W-1:0]   gram_reg;
    logic [GRAM_W-1:0]   eff_gram;

    logic [SYM_W-1:0]    dig_a_reg [MAX_GRAM];
    logic [SYM_W-1:0]    dig_b_reg [MAX_GRAM];
    logic [SYM_W-1:0]    dig_a_next [MAX_GRAM];
    logic [SYM_W-1:0]    dig_b_next [MAX_GRAM];
    logic [ADDR_W-1:0]   term_a [MAX_GRAM];
    logic [ADDR_W-1:0]   term_b [MAX_GRAM];
    logic [ADDR_W-1:0]   bin_a_next;
    logic [ADDR_W-1:0]   bin_b_next;
    logic [ADDR_W-1:0]   bin_a_reg;
    logic [ADDR_W-1:0]   bin_b_reg;

    logic [SEEN_W-1:0]   seen_reg;
    logic [SEEN_W-1:0]   seen_next;
    logic                counting;
    logic                inc_next;
    logic                inc_reg;
    logic                last_reg;

    logic [ADDR_W-1:0]   sweep_reg;
    logic [ADDR_W-1:0]   addr_a;
    logic [ADDR_W-1:0]   addr_b;
    logic                we_a;
    logic                we_b;
    logic [BIN_W-1:0]    wdata_a;
    logic [BIN_W-1:0]    wdata_b;
    logic [BIN_W-1:0]    hist_a_mem [DEPTH];
    logic [BIN_W-1:0]    hist_b_mem [DEPTH];
    logic [BIN_W-1:0]    rd_a_reg;
    logic [BIN_W-1:0]    rd_b_reg;

    logic                sum_rd_reg;
    logic                prod_vld_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [KERNEL_W+1:0] acc_sum;
    logic [KERNEL_W-1:0] acc_reg;
    logic [KERNEL_W-1:0] acc_next;
    logic [SEEN_W-1:0]   win_calc;
    logic [KERNEL_W-1:0] kernel_value_reg;
    logic [WIN_W-1:0]    windows_reg;

    // Hold the gram length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gram_reg <= nsk_pkg::GRAM_RESET;
        end
        else if (cfg_write)
        begin
            gram_reg <= cfg_data;
        end
    end

    // Clamp the gram length into 1..MAX_GRAM
    always_comb
    begin
        if (gram_reg == '0)
        begin
            eff_gram = GRAM_W'(1);
        end
        else if (gram_reg > GRAM_W'(MAX_GRAM))
        begin
            eff_gram = GRAM_W'(MAX_GRAM);
        end
        else
        begin
            eff_gram = gram_reg;
        end
    end

    // Shift the new symbols in, newest digit at position zero; code 3 acts as 2
    always_comb
    begin
        dig_a_next[0] = (symbol_a > nsk_pkg::SYM_MAX) ? nsk_pkg::SYM_MAX : symbol_a;
        dig_b_next[0] = (symbol_b > nsk_pkg::SYM_MAX) ? nsk_pkg::SYM_MAX : symbol_b;
        for (int i = 1; i < MAX_GRAM; i++)
        begin
            dig_a_next[i] = dig_a_reg[i-1];
            dig_b_next[i] = dig_b_reg[i-1];
        end
    end

    // Weight each of the last n digits by its power of three
    for (genvar g = 0; g < MAX_GRAM; g++)
    begin : g_term
        localparam int unsigned WEIGHT = nsk_pkg::pow3(g);
        assign term_a[g] = (GRAM_W'(g) < eff_gram) ?
                           ADDR_W'(dig_a_next[g]) * ADDR_W'(WEIGHT) : '0;
        assign term_b[g] = (GRAM_W'(g) < eff_gram) ?
                           ADDR_W'(dig_b_next[g]) * ADDR_W'(WEIGHT) : '0;
    end

    // Sum the weighted digits into the bin index
    always_comb
    begin
        bin_a_next = '0;
        bin_b_next = '0;
        for (int i = 0; i < MAX_GRAM; i++)
        begin
            bin_a_next = bin_a_next + term_a[i];
            bin_b_next = bin_b_next + term_b[i];
        end
    end

    // Count symbols up to the sequence limit; a window exists once n have arrived
    always_comb
    begin
        counting  = (seen_reg < SEEN_W'(MAX_SEQ_LEN));
        seen_next = seen_reg + 1'b1;
        inc_next  = counting && (seen_next >= SEEN_W'(eff_gram));
    end

    // Advance the window state on each transaction, clear it at pair end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
            inc_reg  <= 1'b0;
            last_reg <= 1'b0;
            for (int i = 0; i < MAX_GRAM; i++)
            begin
                dig_a_reg[i] <= '0;
                dig_b_reg[i] <= '0;
            end
        end
        else if (cmd.finish)
        begin
            seen_reg <= '0;
            inc_reg  <= 1'b0;
            last_reg <= 1'b0;
            for (int i = 0; i < MAX_GRAM; i++)
            begin
                dig_a_reg[i] <= '0;
                dig_b_reg[i] <= '0;
            end
        end
        else if (cmd.load)
        begin
            inc_reg  <= inc_next;
            last_reg <= last;
            if (counting)
            begin
                seen_reg <= seen_next;
                for (int i = 0; i < MAX_GRAM; i++)
                begin
                    dig_a_reg[i] <= dig_a_next[i];
                    dig_b_reg[i] <= dig_b_next[i];
                end
            end
        end
    end

    // Hold the bin addresses of the captured transaction
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bin_a_reg <= bin_a_next;
            bin_b_reg <= bin_b_next;
        end
    end

    // Advance the sweep address, wrapping after the last bin
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg <= '0;
        end
        else if (cmd.sweep)
        begin
            sweep_reg <= sts.sweep_end ? '0 : sweep_reg + 1'b1;
        end
    end

    assign sts.sweep_end = (sweep_reg == ADDR_W'(DEPTH - 1));
    assign sts.last      = last_reg;

    // Select memory address and write data: sweep clears, write-back increments
    always_comb
    begin
        addr_a  = cmd.sweep ? sweep_reg : bin_a_reg;
        addr_b  = cmd.sweep ? sweep_reg : bin_b_reg;
        we_a    = cmd.sweep || (cmd.inc_wr && inc_reg);
        we_b    = cmd.sweep || (cmd.inc_wr && inc_reg);
        wdata_a = cmd.sweep ? '0 :
                  ((rd_a_reg == nsk_pkg::BIN_MAX) ? rd_a_reg : rd_a_reg + 1'b1);
        wdata_b = cmd.sweep ? '0 :
                  ((rd_b_reg == nsk_pkg::BIN_MAX) ? rd_b_reg : rd_b_reg + 1'b1);
    end

    // Histogram memories, read before write
    always_ff @(posedge clk)
    begin
        if (we_a)
        begin
            hist_a_mem[addr_a] <= wdata_a;
        end
        rd_a_reg <= hist_a_mem[addr_a];
    end

    always_ff @(posedge clk)
    begin
        if (we_b)
        begin
            hist_b_mem[addr_b] <= wdata_b;
        end
        rd_b_reg <= hist_b_mem[addr_b];
    end

    // Multiply the bin pair read by the sweep
    always_ff @(posedge clk)
    begin
        prod_reg <= rd_a_reg * rd_b_reg;
    end

    // Saturating accumulate of the products
    always_comb
    begin
        acc_sum = {2'b00, acc_reg} + {1'b0, prod_reg};
        if (cmd.finish)
        begin
            acc_next = '0;
        end
        else if (prod_vld_reg)
        begin
            acc_next = (acc_sum > (KERNEL_W + 2)'(nsk_pkg::KERNEL_MAX)) ?
                       nsk_pkg::KERNEL_MAX : acc_sum[KERNEL_W-1:0];
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_rd_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            sum_rd_reg   <= cmd.sum;
            prod_vld_reg <= sum_rd_reg;
            acc_reg      <= acc_next;
        end
    end

    // Windows per sequence: symbols counted less n, plus one
    always_comb
    begin
        if (seen_reg >= SEEN_W'(eff_gram))
        begin
            win_calc = seen_reg - SEEN_W'(eff_gram) + 1'b1;
        end
        else
        begin
            win_calc = '0;
        end
    end

    // Hold the result for the output channel
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            kernel_value_reg <= acc_reg;
            windows_reg      <= WIN_W'(win_calc);
        end
    end

    assign kernel_value    = kernel_value_reg;
    assign windows_counted = windows_reg;

endmodule

`default_nettype wire

### hdl/ngram_spectrum_kernel_core.sv
// Top level of the n-gram spectrum kernel: controller, datapath and checks.
// Loading: each symbol pair passes a read state and a write-back state of one histogram
//   memory port per sequence; the next item can be taken during the write-back state.
// Last item: read, write-back, a sweep of all 3^MAX_GRAM bins, flush states to drain the
//   multiply and accumulate stages; the result is then loaded into the output register.
// Reset: a clearing pass over all 3^MAX_GRAM bins (6561 by default) zeroes the histograms;
//   no input transaction is taken until it ends, configuration writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none

module ngram_spectrum_kernel_core
#(
    parameter int unsigned MAX_GRAM    = nsk_pkg::MAX_GRAM_DEF,
    parameter int unsigned MAX_SEQ_LEN = nsk_pkg::MAX_SEQ_LEN_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [nsk_pkg::GRAM_W-1:0]    cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [nsk_pkg::SYM_W-1:0]     symbol_a,
    input  wire logic [nsk_pkg::SYM_W-1:0]     symbol_b,
    input  wire logic                          last,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [nsk_pkg::KERNEL_W-1:0]       kernel_value,
    output logic [nsk_pkg::WIN_W-1:0]          windows_counted
);

    nsk_pkg::nsk_cmd_t cmd;
    nsk_pkg::nsk_sts_t sts;

    nsk_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    nsk_datapath
    #(
        .MAX_GRAM    (MAX_GRAM),
        .MAX_SEQ_LEN (MAX_SEQ_LEN)
    )
    u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_data        (cfg_data),
        .symbol_a        (symbol_a),
        .symbol_b        (symbol_b),
        .last            (last),
        .cmd             (cmd),
        .sts             (sts),
        .kernel_value    (kernel_value),
        .windows_counted (windows_counted)
    );

    // A histogram sweep never overlaps an input transaction
    a_sweep_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sweep |-> in_stall)
        else $error("input taken during histogram sweep");

    // A result appears only after the controller publishes one
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.finish))
        else $error("result valid without finish");

    // A taken result drops valid unless a new one is published
    a_result_taken_once: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !cmd.finish) |=> !out_valid)
        else $error("result repeated after transaction");

    // No write-back or capture while the sweep owns the memory port
    a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.sweep && (cmd.inc_wr || cmd.load)))
        else $error("memory port conflict");

endmodule

`default_nettype wire

### verif/ngram_spectrum_kernel_core_test.sv
// Self-checking testbench for the n-gram spectrum kernel core.
`timescale 1ns / 1ps

module ngram_spectrum_kernel_core_test;

    // Field widths taken from the package
    localparam int unsigned GRAM_W   = nsk_pkg::GRAM_W;
    localparam int unsigned SYM_W    = nsk_pkg::SYM_W;
    localparam int unsigned BIN_W    = nsk_pkg::BIN_W;
    localparam int unsigned KERNEL_W = nsk_pkg::KERNEL_W;
    localparam int unsigned WIN_W    = nsk_pkg::WIN_W;

    // Bins per histogram: 3^MAX_GRAM_DEF
    localparam int unsigned HIST_BINS = 6561;
    localparam int unsigned TRIT_SCALE [0:8] = '{1, 3, 9, 27, 81, 243, 729, 2187, 6561};
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned SQUEEZE_CYCLES = 20000;

    typedef struct packed {
        logic [KERNEL_W-1:0] kernel;
        logic [WIN_W-1:0]    windows;
    } spectrum_result_t;

    // One directed transaction, optionally preceded by a length change
    typedef struct packed {
        logic                cfg_now;
        logic [GRAM_W-1:0]   gram;
        logic [SYM_W-1:0]    sym_a;
        logic [SYM_W-1:0]    sym_b;
        logic                closes;
        logic                typed;
        logic [KERNEL_W-1:0] kernel;
        logic [WIN_W-1:0]    windows;
    } stim_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_write;
    logic [GRAM_W-1:0]   cfg_data;
    logic                in_valid;
    logic                in_stall;
    logic [SYM_W-1:0]    symbol_a;
    logic [SYM_W-1:0]    symbol_b;
    logic                last;
    logic                out_valid;
    logic                out_stall;
    logic [KERNEL_W-1:0] kernel_value;
    logic [WIN_W-1:0]    windows_counted;

    // Predicted spectrum state
    logic [BIN_W-1:0]    bins_a [HIST_BINS];
    logic [BIN_W-1:0]    bins_b [HIST_BINS];
    logic [12:0]         trail_a;
    logic [12:0]         trail_b;
    logic [16:0]         symbols_taken;
    logic [GRAM_W-1:0]   gram_reg;

    spectrum_result_t    pending_kernels [$];
    int unsigned         fault_count = 0;
    bit                  calm = 1'b0;
    bit                  squeeze_req = 1'b0;
    bit                  hold_active = 1'b0;

    stim_row_t directed_rows [24] = '{
        // short sequence at the reset length
        '{1'b0, 4'd0,  2'd0, 2'd0, 1'b1, 1'b1, 33'd0, 17'd0},
        // code 3 acts as 2, single-symbol windows
        '{1'b1, 4'd1,  2'd3, 2'd3, 1'b1, 1'b1, 33'd1, 17'd1},
        // length 0 acts as 1
        '{1'b1, 4'd0,  2'd1, 2'd1, 1'b0, 1'b0, 33'd0, 17'd0},
        '{1'b0, 4'd0,  2'd1, 2'd2, 1'b1, 1'b1, 33'd2, 17'd2},
        // length 15 acts as 8: one window on the top bin
        '{1'b1, 4'd15, 2'd2, 2'd3, 1'b0, 1'b0, 33'd0, 17'd0},
        '{1'b0, 4'd0,  2'd3, 2'd2, 1'b0, 1'b0, 33'd0, 17'd0},
        '{1'b0, 4'd0,  2'd2, 2'd2, 1'b0, 1'b0, 33'd0, 17'd0},
        '{1'b0, 4'd0,  2'd2, 2'd3, 1'b0, 1'b0, 33'd0, 17'd0},
        '{1'b0, 4'd0,  2'd3, 2'd3, 1'b0, 1'b0, 33'd0, 17'd0},
        '{1'b0, 4'd0,  2'd2, 2'd2, 1'b0, 1'b0, 33'd0, 17'd0},
        '{1'b0, 4'd0,  2'd3, 2'd2, 1'b0, 1'b0, 33'd0, 17'd0},
        '{1'b0, 4'd0,  2'd2, 2'd2, 1'b1, 1'b1, 33'd1, 17'd1},
        // length change in the middle of a pair
        '{1'b1, 4'd2,  2'd0, 2'd0, 1'b0, 1'b0, 33'd0, 17'd0},
        '{1'b0, 4'd0,  2'd1, 2'd1, 1'b0, 1'b0, 33'd0, 17'd0},
        '{1'b1, 4'd1,  2'd2, 2'd0, 1'b0, 1'b0, 33'd0, 17'd0},
        '{1'b0, 4'd0,  2'd0, 2'd2, 1'b1, 1'b0, 33'd0, 17'd0},
        // mixed codes at length 4
        '{1'b1, 4'd4,  2'd3, 2'd0, 1'b0, 1'b0, 33'd0, 17'd0},
        '{1'b0, 4'd0,  2'd0, 2'd3, 1'b0, 1'b0, 33'd0, 17'd0},
        '{1'b0, 4'd0,  2'd1, 2'd2, 1'b0, 1'b0, 33'd0, 17'd0},
        '{1'b0, 4'd0,  2'd2, 2'd1, 1'b0, 1'b0, 33'd0, 17'd0},
        '{1'b0, 4'd0,  2'd3, 2'd3, 1'b1, 1'b0, 33'd0, 17'd0},
        // too few symbols for the longest window
        '{1'b1, 4'd8,  2'd0, 2'd1, 1'b0, 1'b0, 33'd0, 17'd0},
        '{1'b0, 4'd0,  2'd1, 2'd0, 1'b0, 1'b0, 33'd0, 17'd0},
        '{1'b0, 4'd0,  2'd2, 2'd2, 1'b1, 1'b1, 33'd0, 17'd0}
    };

    ngram_spectrum_kernel_core dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .symbol_a        (symbol_a),
        .symbol_b        (symbol_b),
        .last            (last),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .kernel_value    (kernel_value),
        .windows_counted (windows_counted)
    );

    always #4 clk = ~clk;

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        fault_count++;
    endtask

    // Drop all per-pair state
    function automatic void clear_spectrum();
        for (int unsigned i = 0; i < HIST_BINS; i++)
        begin
            bins_a[i] = '0;
            bins_b[i] = '0;
        end
        trail_a = '0;
        trail_b = '0;
        symbols_taken = '0;
    endfunction

    // Advance the spectrum by one symbol pair; returns 1 when a kernel is due
    function automatic bit fold_symbols(input logic [SYM_W-1:0] sa, input logic [SYM_W-1:0] sb,
                                        input logic closes, output spectrum_result_t res);
        int unsigned     n;
        int unsigned     ia;
        int unsigned     ib;
        int unsigned     span;
        logic [SYM_W-1:0] ca;
        logic [SYM_W-1:0] cb;
        longint unsigned dot;
        n = (gram_reg == 0) ? 1 :
            (gram_reg > nsk_pkg::MAX_GRAM_DEF) ? nsk_pkg::MAX_GRAM_DEF : gram_reg;
        ca = (sa > nsk_pkg::SYM_MAX) ? nsk_pkg::SYM_MAX : sa;
        cb = (sb > nsk_pkg::SYM_MAX) ? nsk_pkg::SYM_MAX : sb;
        res = '0;
        if (symbols_taken < nsk_pkg::MAX_SEQ_LEN_DEF)
        begin
            ia = (int'(trail_a) * 3 + ca) % HIST_BINS;
            ib = (int'(trail_b) * 3 + cb) % HIST_BINS;
            trail_a = ia[12:0];
            trail_b = ib[12:0];
            symbols_taken++;
            if (symbols_taken >= n)
            begin
                span = TRIT_SCALE[n];
                if (bins_a[ia % span] != nsk_pkg::BIN_MAX)
                    bins_a[ia % span]++;
                if (bins_b[ib % span] != nsk_pkg::BIN_MAX)
                    bins_b[ib % span]++;
            end
        end
        if (!closes)
            return 1'b0;
        // Dot product over every bin, saturating
        dot = 0;
        for (int unsigned i = 0; i < HIST_BINS; i++)
        begin
            dot += 64'(bins_a[i]) * 64'(bins_b[i]);
            if (dot > 64'(nsk_pkg::KERNEL_MAX))
                dot = 64'(nsk_pkg::KERNEL_MAX);
        end
        res.kernel = dot[KERNEL_W-1:0];
        res.windows = (symbols_taken >= n) ? WIN_W'(symbols_taken - n + 1) : '0;
        clear_spectrum();
        return 1'b1;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int unsigned pause_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned pick_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 20);
        if (r < 95)
            return $urandom_range(21, 60);
        return $urandom_range(61, 250);
    endfunction

    function automatic logic [GRAM_W-1:0] pick_gram();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return GRAM_W'($urandom_range(1, 3));
        if (r < 55)
            return '0;
        if (r < 70)
            return GRAM_W'($urandom_range(nsk_pkg::MAX_GRAM_DEF, 15));
        return GRAM_W'($urandom_range(4, nsk_pkg::MAX_GRAM_DEF - 1));
    endfunction

    // Offer one transaction, hold it until taken, then predict
    task automatic offer_symbols(input logic [SYM_W-1:0] sa, input logic [SYM_W-1:0] sb,
                                 input logic closes, input bit typed,
                                 input spectrum_result_t want);
        int unsigned      gap;
        spectrum_result_t res;
        gap = calm ? 0 : pause_length();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        symbol_a <= sa;
        symbol_b <= sb;
        last     <= closes;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        if (fold_symbols(sa, sb, closes, res))
            pending_kernels.push_back(typed ? want : res);
    endtask

    // Stop offering and wait until the core has gone quiet
    task automatic settle_block();
        in_valid <= 1'b0;
        while (pending_kernels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_gram(input logic [GRAM_W-1:0] g);
        cfg_write <= 1'b1;
        cfg_data  <= g;
        @(posedge clk);
        cfg_write <= 1'b0;
        gram_reg = g;
    endtask

    // Result side: random stall, one long hold-off on request
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (squeeze_req)
            begin
                squeeze_req = 1'b0;
                hold_active = 1'b1;
                out_stall <= 1'b1;
                repeat (SQUEEZE_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_active = 1'b0;
            end
            else if (calm)
                out_stall <= 1'b0;
            else
            begin
                out_stall <= ($urandom_range(0, 99) < 40);
                repeat (pause_length()) @(posedge clk);
            end
        end
    end

    // Check each result transaction against the oldest prediction
    always @(posedge clk)
    begin
        spectrum_result_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_kernels.size() == 0)
                report_mismatch("unexpected kernel_value", 64'(kernel_value), 64'd0);
            else
            begin
                want = pending_kernels.pop_front();
                if (kernel_value !== want.kernel)
                    report_mismatch("kernel_value", 64'(kernel_value), 64'(want.kernel));
                if (windows_counted !== want.windows)
                    report_mismatch("windows_counted", 64'(windows_counted),
                                    64'(want.windows));
            end
        end
    end

    // Stimulus
    initial
    begin
        int unsigned      pairs;
        int unsigned      items;
        int unsigned      len;
        int unsigned      split;
        int unsigned      mode;
        int unsigned      r;
        logic [SYM_W-1:0] fixed_sym;
        logic [SYM_W-1:0] sa;
        logic [SYM_W-1:0] sb;
        spectrum_result_t want;

        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        symbol_a  <= '0;
        symbol_b  <= '0;
        last      <= 1'b0;
        gram_reg = nsk_pkg::GRAM_RESET;
        clear_spectrum();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].cfg_now)
            begin
                settle_block();
                write_gram(directed_rows[i].gram);
            end
            want.kernel  = directed_rows[i].kernel;
            want.windows = directed_rows[i].windows;
            offer_symbols(directed_rows[i].sym_a, directed_rows[i].sym_b,
                          directed_rows[i].closes, directed_rows[i].typed, want);
        end

        // Random pairs
        pairs = 0;
        items = 0;
        want = '0;
        while ((items < 1300 || pairs < 48) && pairs < 75)
        begin
            calm = ($urandom_range(0, 99) < 20);
            // Squeeze the output early on while input keeps flowing
            if (pairs == 3)
            begin
                calm = 1'b0;
                squeeze_req = 1'b1;
            end
            if (!squeeze_req && !hold_active)
            begin
                r = $urandom_range(0, 99);
                if (r < 30)
                begin
                    settle_block();
                    write_gram(pick_gram());
                end
                else if (r < 38)
                    settle_block();
            end
            len = pick_length();
            mode = $urandom_range(0, 2);
            fixed_sym = SYM_W'($urandom_range(0, 3));
            split = 0;
            if (len > 2 && !squeeze_req && !hold_active && $urandom_range(0, 99) < 12)
                split = $urandom_range(1, len - 1);
            for (int unsigned k = 0; k < len; k++)
            begin
                if (split != 0 && k == split)
                begin
                    settle_block();
                    write_gram(pick_gram());
                end
                sb = SYM_W'($urandom_range(0, 3));
                sa = SYM_W'($urandom_range(0, 3));
                if (mode == 1 && $urandom_range(0, 99) < 80)
                begin
                    // long runs of one code
                    sa = fixed_sym;
                    sb = fixed_sym;
                end
                else if (mode == 2 && $urandom_range(0, 99) < 85)
                    sa = sb;
                offer_symbols(sa, sb, (k == len - 1), 1'b0, want);
                items++;
            end
            pairs++;
        end
        in_valid <= 1'b0;

        // Drain and let any stray result show up
        while (pending_kernels.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fault_count == 0)
            $display("ngram_spectrum_kernel_core_test: done, clean");
        else
            $display("ngram_spectrum_kernel_core_test: done, errors");
        $finish;
    end

    // Watchdog
    initial
    begin
        #40000000;
        $display("%0t ns: timeout", $time);
        $display("ngram_spectrum_kernel_core_test: done, errors");
        $finish;
    end

endmodule
